### sv/rtcep_pkg.sv
`timescale 1ns / 1ps
// rtcep_pkg: shared types, constants and small decode functions for the
// rtc fields to epoch seconds pipeline; no dependencies

package rtcep_pkg;

   typedef logic [7:0] rtc_byte_type;

   typedef struct packed {
      logic adv;
      logic valid;
   } pipe_ctl_type;

   // julian day number terms
   localparam logic [12:0] YEAR_BIAS_P  = 13'd4799;  // 4800 plus month adjust of -1
   localparam logic [12:0] YEAR_BIAS_Q  = 13'd4899;  // 4900 plus month adjust of -1
   localparam logic [10:0] DAYS_PER_4Y  = 11'd1461;
   localparam logic [6:0]  YEARS_PER_C  = 7'd100;
   localparam logic [23:0] JDN_OFFSET   = 24'd2472663; // 32075 plus jdn of 1970-01-01

   // reciprocal constants for division by 12 and by 100
   localparam logic [7:0]  RECIP_12       = 8'd171;
   localparam int          RECIP_12_SHIFT = 11;
   localparam logic [12:0] RECIP_100       = 13'd5243;
   localparam int          RECIP_100_SHIFT = 19;

   localparam logic [11:0] SECS_PER_HOUR = 12'd3600;
   localparam logic [5:0]  SECS_PER_MIN  = 6'd60;
   localparam logic signed [41:0] SECS_PER_DAY = 42'sd86400;

   function automatic rtc_byte_type bcd_decode(input rtc_byte_type raw, input logic binary);
      logic [7:0] tens;
      tens = {1'b0, raw[7:4], 3'b000} + {3'b000, raw[7:4], 1'b0};
      return binary ? raw : (tens + {4'b0000, raw[3:0]});
   endfunction

   // floor(367 * m / 12) for the shifted month term 0..23
   function automatic logic [9:0] month_days(input logic [4:0] mterm);
      logic [9:0] days;
      case (mterm)
         5'd0:    days = 10'd0;
         5'd1:    days = 10'd30;
         5'd2:    days = 10'd61;
         5'd3:    days = 10'd91;
         5'd4:    days = 10'd122;
         5'd5:    days = 10'd152;
         5'd6:    days = 10'd183;
         5'd7:    days = 10'd214;
         5'd8:    days = 10'd244;
         5'd9:    days = 10'd275;
         5'd10:   days = 10'd305;
         5'd11:   days = 10'd336;
         5'd12:   days = 10'd367;
         5'd13:   days = 10'd397;
         5'd14:   days = 10'd428;
         5'd15:   days = 10'd458;
         5'd16:   days = 10'd489;
         5'd17:   days = 10'd519;
         5'd18:   days = 10'd550;
         5'd19:   days = 10'd581;
         5'd20:   days = 10'd611;
         5'd21:   days = 10'd642;
         5'd22:   days = 10'd672;
         5'd23:   days = 10'd703;
         default: days = 10'd0;
      endcase
      return days;
   endfunction

endpackage

### sv/rtcep_day_pipe.sv
`timescale 1ns / 1ps
// rtcep_day_pipe: three-stage pipeline from decoded century, year, month and
// day to the signed day count since 1970-01-01; uses rtcep_pkg

module rtcep_day_pipe
   import rtcep_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  pipe_ctl_type       ctl,
   input  rtc_byte_type       cent,
   input  rtc_byte_type       yr,
   input  rtc_byte_type       mon,
   input  rtc_byte_type       day,
   output logic               out_valid,
   output logic signed [24:0] day_diff
);

   // stage 2: full year, month adjust
   logic        v2_ff;
   logic [14:0] full_year_in, full_year_ff;
   logic [4:0]  a_p1_in, a_p1_ff;
   logic [4:0]  mterm_in, mterm_ff;
   logic [7:0]  day2_ff;
   logic [7:0]  mx;
   logic [15:0] q12_prod;
   logic [4:0]  q12;
   logic [7:0]  r12;

   always_comb begin
      full_year_in = 15'({7'b0, cent} * 15'(YEARS_PER_C)) + {7'b0, yr};
      mx           = mon - 8'd14;
      q12_prod     = {8'b0, mx} * {8'b0, RECIP_12};
      q12          = q12_prod[RECIP_12_SHIFT +: 5];
      r12          = mx - ({3'b000, q12} * 8'd12);
      if (mon < 8'd3) begin
         a_p1_in  = 5'd0;
         mterm_in = mon[4:0] + 5'd10;
      end else if (mon < 8'd14) begin
         a_p1_in  = 5'd1;
         mterm_in = mon[4:0] - 5'd2;
      end else begin
         a_p1_in  = q12 + 5'd1;
         mterm_in = 5'd12 + {1'b0, r12[3:0]};
      end
   end

   // stage 3: year and month terms
   logic        v3_ff;
   logic [15:0] p_sum, q_sum;
   logic [26:0] t1_prod;
   logic [28:0] c_prod;
   logic [23:0] t1_in, t1_ff;
   logic [8:0]  c_in, c_ff;
   logic [9:0]  t2_in, t2_ff;
   logic [7:0]  day3_ff;

   always_comb begin
      p_sum   = {1'b0, full_year_ff} + {3'b000, YEAR_BIAS_P} + {11'b0, a_p1_ff};
      q_sum   = {1'b0, full_year_ff} + {3'b000, YEAR_BIAS_Q} + {11'b0, a_p1_ff};
      t1_prod = 27'(p_sum) * 27'(DAYS_PER_4Y);
      c_prod  = 29'(q_sum) * 29'(RECIP_100);
      t1_in   = t1_prod[25:2];
      c_in    = c_prod[RECIP_100_SHIFT +: 9];
      t2_in   = month_days(mterm_ff);
   end

   // stage 4: day difference
   logic        v4_ff;
   logic [9:0]  t3_full;
   logic [7:0]  t3;
   logic [24:0] diff_in;
   logic [24:0] diff_ff;

   always_comb begin
      t3_full = {c_ff, 1'b0} + {1'b0, c_ff};
      t3      = t3_full[9:2];
      diff_in = 25'(t1_ff) + 25'(t2_ff) + 25'(day3_ff) - 25'(t3) - 25'(JDN_OFFSET);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (ctl.adv) begin
         v2_ff <= ctl.valid;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.adv) begin
         full_year_ff <= full_year_in;
         a_p1_ff      <= a_p1_in;
         mterm_ff     <= mterm_in;
         day2_ff      <= day;
         t1_ff        <= t1_in;
         c_ff         <= c_in;
         t2_ff        <= t2_in;
         day3_ff      <= day2_ff;
         diff_ff      <= diff_in;
      end
   end

   assign out_valid = v4_ff;
   assign day_diff  = $signed(diff_ff);

endmodule

### sv/rtc_fields_to_epoch_seconds_unit.sv
`timescale 1ns / 1ps
// rtc_fields_to_epoch_seconds_unit: top level, byte decode, time of day,
// seconds scaling and output register; uses rtcep_pkg and rtcep_day_pipe
//
// Converts one set of raw rtc bytes (seconds, minutes, hours, day, month,
// two-digit year, century) into signed 64-bit seconds since 1970-01-01.
// csr_wr_en/csr_wr_data set binary mode: 1 takes bytes as plain binary,
// 0 decodes packed bcd. Reset clears it to bcd.
// Requests enter on req_valid/req_ready, results leave on rsp_valid/rsp_ready.
// Six register stages: decode, full year and time of day, julian terms,
// day difference, day times 86400, final add into the output register.
// An accepted request passes through each stage in order to rsp_.
// Throughput is one request per cycle while the receiver does not stall;
// the multiplier stages set the stage depth.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and req_ready drops; nothing is lost or repeated.
// Reset empties the pipeline; rsp_valid is low right after reset.

module rtc_fields_to_epoch_seconds_unit
   import rtcep_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wr_en,
   input  logic               csr_wr_data,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_seconds_raw,
   input  logic [7:0]         req_minutes_raw,
   input  logic [7:0]         req_hours_raw,
   input  logic [7:0]         req_day_raw,
   input  logic [7:0]         req_month_raw,
   input  logic [7:0]         req_year_raw,
   input  logic [7:0]         req_century_raw,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [63:0] rsp_epoch_seconds
);

   logic binary_mode_ff;
   logic adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         binary_mode_ff <= 1'b0;
      end else if (csr_wr_en) begin
         binary_mode_ff <= csr_wr_data;
      end
   end

   logic rsp_valid_ff;
   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv;

   // stage 1: byte decode
   logic         v1_ff;
   rtc_byte_type sec1_ff, min1_ff, hr1_ff, day1_ff, mon1_ff, yr1_ff, cent1_ff;

   // stages 2..4: time of day carried beside the day pipeline
   logic [19:0]  hms_in, hms2_ff, hms3_ff, hms4_ff;

   always_comb begin
      hms_in = (20'(hr1_ff) * 20'(SECS_PER_HOUR)) + (20'(min1_ff) * 20'(SECS_PER_MIN))
             + 20'(sec1_ff);
   end

   pipe_ctl_type        day_ctl;
   logic                day_valid;
   logic signed [24:0]  day_diff;

   assign day_ctl.adv   = adv;
   assign day_ctl.valid = v1_ff;

   rtcep_day_pipe u_day_pipe (
      .clock     (clock),
      .reset     (reset),
      .ctl       (day_ctl),
      .cent      (cent1_ff),
      .yr        (yr1_ff),
      .mon       (mon1_ff),
      .day       (day1_ff),
      .out_valid (day_valid),
      .day_diff  (day_diff)
   );

   // stage 5: scale days to seconds
   logic               v5_ff;
   logic signed [41:0] prod_in, prod_ff;
   logic [19:0]        hms5_ff;

   assign prod_in = 42'(day_diff) * SECS_PER_DAY;

   // stage 6: output register
   logic [63:0] total_in;
   logic [63:0] total_ff;

   assign total_in = {{22{prod_ff[41]}}, prod_ff} + {44'b0, hms5_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v5_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         v1_ff        <= req_valid;
         v5_ff        <= day_valid;
         rsp_valid_ff <= v5_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sec1_ff  <= bcd_decode(req_seconds_raw, binary_mode_ff);
         min1_ff  <= bcd_decode(req_minutes_raw, binary_mode_ff);
         hr1_ff   <= bcd_decode(req_hours_raw, binary_mode_ff);
         day1_ff  <= bcd_decode(req_day_raw, binary_mode_ff);
         mon1_ff  <= bcd_decode(req_month_raw, binary_mode_ff);
         yr1_ff   <= bcd_decode(req_year_raw, binary_mode_ff);
         cent1_ff <= bcd_decode(req_century_raw, binary_mode_ff);
         hms2_ff  <= hms_in;
         hms3_ff  <= hms2_ff;
         hms4_ff  <= hms3_ff;
         hms5_ff  <= hms4_ff;
         prod_ff  <= prod_in;
         total_ff <= total_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_epoch_seconds = $signed(total_ff);

   // assertions
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid_ff)
      else $error("result valid right after reset");

   a_stall_holds_stage5: assert property (@(posedge clock) disable iff (reset)
      (!adv && v5_ff) |=> (v5_ff && $stable(prod_ff) && $stable(hms5_ff)))
      else $error("stage 5 changed during stall");

   a_hms_range: assert property (@(posedge clock) disable iff (reset)
      v5_ff |-> (hms5_ff <= 20'd933555))
      else $error("time of day out of range");

   a_day_range: assert property (@(posedge clock) disable iff (reset)
      day_valid |-> ((day_diff >= -25'sd720000) && (day_diff <= 25'sd8700000)))
      else $error("day difference out of range");

   a_bcd_range: assert property (@(posedge clock) disable iff (reset)
      (v1_ff && !binary_mode_ff && $past(adv) && !$past(csr_wr_en))
      |-> (mon1_ff <= 8'd165 && cent1_ff <= 8'd165))
      else $error("bcd decode out of range");

endmodule

### dv/rtc_fields_to_epoch_seconds_unit_tb.sv
`timescale 1ns / 1ps
// rtc_fields_to_epoch_seconds_unit_tb: self-checking bench for the rtc bytes to epoch seconds unit
// queue-fed request driver, stalling receiver and a scoreboard against a julian-day predictor
// depends on rtcep_pkg and rtc_fields_to_epoch_seconds_unit

module rtc_fields_to_epoch_seconds_unit_tb
   import rtcep_pkg::*;
();

   typedef struct packed {
      rtc_byte_type sec;
      rtc_byte_type min;
      rtc_byte_type hr;
      rtc_byte_type day;
      rtc_byte_type mon;
      rtc_byte_type yr;
      rtc_byte_type cent;
   } rtc_stamp_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               csr_wr_en = 1'b0;
   logic               csr_wr_data = 1'b0;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [7:0]         req_seconds_raw = 8'h00;
   logic [7:0]         req_minutes_raw = 8'h00;
   logic [7:0]         req_hours_raw = 8'h00;
   logic [7:0]         req_day_raw = 8'h00;
   logic [7:0]         req_month_raw = 8'h00;
   logic [7:0]         req_year_raw = 8'h00;
   logic [7:0]         req_century_raw = 8'h00;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic signed [63:0] rsp_epoch_seconds;

   rtc_stamp_type      pending_stamps[$];
   logic signed [63:0] expected_epochs[$];
   bit                 binary_model = 1'b0;
   bit                 req_fire = 1'b0;
   int                 queued_count = 0;
   int                 accepted_count = 0;
   int                 checked_count = 0;
   int                 mismatch_count = 0;
   int                 csr_writes = 0;
   int                 burst_left = 1;
   int                 gap_left = 0;
   int                 stall_mode = 0;
   int                 stall_left = 0;
   int unsigned        stall_cycle = 0;

   rtc_fields_to_epoch_seconds_unit dut (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_seconds_raw   (req_seconds_raw),
      .req_minutes_raw   (req_minutes_raw),
      .req_hours_raw     (req_hours_raw),
      .req_day_raw       (req_day_raw),
      .req_month_raw     (req_month_raw),
      .req_year_raw      (req_year_raw),
      .req_century_raw   (req_century_raw),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_epoch_seconds (rsp_epoch_seconds)
   );

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   function automatic longint decode_rtc_byte(rtc_byte_type raw, bit binary);
      if (binary) return longint'(raw);
      return longint'(raw[3:0]) + longint'(raw[7:4]) * 10;
   endfunction

   function automatic longint day_number(longint d, longint m, longint y);
      longint a;
      a = (m - 14) / 12;
      return (1461 * (y + 4800 + a)) / 4 + (367 * (m - 2 - 12 * a)) / 12
             - (3 * ((y + 4900 + a) / 100)) / 4 + d - 32075;
   endfunction

   function automatic logic signed [63:0] predict_epoch_seconds(rtc_stamp_type s, bit binary);
      longint full_year;
      longint days;
      full_year = decode_rtc_byte(s.cent, binary) * 100 + decode_rtc_byte(s.yr, binary);
      days = day_number(decode_rtc_byte(s.day, binary), decode_rtc_byte(s.mon, binary), full_year)
             - day_number(1, 1, 1970);
      return days * 86400 + decode_rtc_byte(s.hr, binary) * 3600
             + decode_rtc_byte(s.min, binary) * 60 + decode_rtc_byte(s.sec, binary);
   endfunction

   function automatic rtc_byte_type encode_rtc_byte(int v, bit binary);
      if (binary) return rtc_byte_type'(v);
      return rtc_byte_type'(((v / 10) << 4) | (v % 10));
   endfunction

   function automatic rtc_stamp_type random_stamp(bit binary);
      rtc_stamp_type s;
      int            pick;
      pick = $urandom_range(0, 9);
      s.sec  = encode_rtc_byte($urandom_range(0, 59), binary);
      s.min  = encode_rtc_byte($urandom_range(0, 59), binary);
      s.hr   = encode_rtc_byte($urandom_range(0, 23), binary);
      s.day  = encode_rtc_byte($urandom_range(1, 31), binary);
      s.mon  = encode_rtc_byte($urandom_range(1, 12), binary);
      s.yr   = encode_rtc_byte($urandom_range(0, 99), binary);
      s.cent = encode_rtc_byte(($urandom_range(0, 9) < 7) ? $urandom_range(19, 20)
                                                          : $urandom_range(0, 99), binary);
      if (pick == 7) begin
         case ($urandom_range(0, 6))
            0: s.sec  = rtc_byte_type'($urandom_range(0, 255));
            1: s.min  = rtc_byte_type'($urandom_range(0, 255));
            2: s.hr   = rtc_byte_type'($urandom_range(0, 255));
            3: s.day  = rtc_byte_type'($urandom_range(0, 255));
            4: s.mon  = rtc_byte_type'($urandom_range(0, 255));
            5: s.yr   = rtc_byte_type'($urandom_range(0, 255));
            default: s.cent = rtc_byte_type'($urandom_range(0, 255));
         endcase
      end else if (pick >= 8) begin
         s = rtc_stamp_type'(56'({$urandom, $urandom}));
      end
      return s;
   endfunction

   task automatic queue_stamp(input rtc_stamp_type s);
      pending_stamps.push_back(s);
      queued_count++;
   endtask

   task automatic queue_fields(input rtc_byte_type sec, input rtc_byte_type min,
                               input rtc_byte_type hr, input rtc_byte_type day,
                               input rtc_byte_type mon, input rtc_byte_type yr,
                               input rtc_byte_type cent);
      queue_stamp('{sec, min, hr, day, mon, yr, cent});
   endtask

   task automatic report_mismatch(input string what, input logic signed [63:0] got,
                                  input logic signed [63:0] want);
      $display("mismatch at %0t: %s, got %0d expected %0d", $realtime, what, got, want);
      mismatch_count++;
   endtask

   task automatic wait_for_drain();
      do @(negedge clock);
      while (accepted_count != queued_count || expected_epochs.size() != 0);
   endtask

   task automatic write_binary_mode(input bit value);
      repeat (6) @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      binary_model = value;
      csr_writes++;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   always @(negedge clock) begin : drive_requests
      rtc_stamp_type s;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fire) begin
         if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            req_valid <= 1'b0;
         end else if (pending_stamps.size() > 0) begin
            s = pending_stamps.pop_front();
            req_seconds_raw <= s.sec;
            req_minutes_raw <= s.min;
            req_hours_raw <= s.hr;
            req_day_raw <= s.day;
            req_month_raw <= s.mon;
            req_year_raw <= s.yr;
            req_century_raw <= s.cent;
            req_valid <= 1'b1;
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 24);
               case ($urandom_range(0, 3))
                  0: gap_left <= 0;
                  1: gap_left <= 1;
                  2: gap_left <= $urandom_range(0, 4);
                  default: gap_left <= $urandom_range(5, 12);
               endcase
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      stall_cycle <= stall_cycle + 1;
      if (stall_left == 0) begin
         stall_mode <= $urandom_range(0, 3);
         stall_left <= $urandom_range(16, 80);
      end else begin
         stall_left <= stall_left - 1;
      end
      case (stall_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= 1'($urandom_range(0, 1));
         2: rsp_ready <= ($urandom_range(0, 3) == 0);
         default: rsp_ready <= stall_cycle[2];
      endcase
   end

   always @(posedge clock) begin : check_results
      rtc_stamp_type      seen;
      logic signed [63:0] want;
      if (reset) begin
         req_fire = 1'b0;
      end else begin
         req_fire = req_valid && req_ready;
         if (req_fire) begin
            seen = {req_seconds_raw, req_minutes_raw, req_hours_raw, req_day_raw,
                    req_month_raw, req_year_raw, req_century_raw};
            expected_epochs.push_back(predict_epoch_seconds(seen, binary_model));
            accepted_count++;
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_epochs.size() == 0) begin
               report_mismatch("result with no request outstanding", rsp_epoch_seconds, 0);
            end else begin
               want = expected_epochs.pop_front();
               checked_count++;
               if (rsp_epoch_seconds !== want)
                  report_mismatch("epoch_seconds", rsp_epoch_seconds, want);
            end
         end
      end
   end

   initial begin
      #2_000_000;
      $display("timeout with %0d results outstanding", expected_epochs.size());
      $display("Some tests failed");
      $finish;
   end

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // bcd mode from reset
      queue_fields(8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'h70, 8'h19);
      queue_fields(8'h59, 8'h59, 8'h23, 8'h31, 8'h12, 8'h69, 8'h19);
      queue_fields(8'h07, 8'h14, 8'h03, 8'h19, 8'h01, 8'h38, 8'h20);
      queue_fields(8'h00, 8'h00, 8'h00, 8'h29, 8'h02, 8'h00, 8'h20);
      queue_fields(8'h59, 8'h59, 8'h23, 8'h31, 8'h12, 8'h99, 8'h99);
      queue_fields(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
      queue_fields(8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff);
      queue_fields(8'h00, 8'h00, 8'h00, 8'h01, 8'h14, 8'h24, 8'h20);
      queue_fields(8'h00, 8'h00, 8'h00, 8'h01, 8'h02, 8'h00, 8'h19);
      queue_fields(8'h00, 8'h00, 8'h00, 8'h01, 8'h03, 8'h00, 8'h21);
      queue_fields(8'h0a, 8'h0b, 8'h0c, 8'h0d, 8'h0e, 8'h0f, 8'h1a);
      queue_fields(8'ha0, 8'hb0, 8'hc0, 8'hd0, 8'he0, 8'hf0, 8'hf9);
      wait_for_drain();

      write_binary_mode(1'b1);
      queue_fields(8'd0, 8'd0, 8'd0, 8'd1, 8'd1, 8'd70, 8'd19);
      queue_fields(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
      queue_fields(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
      queue_fields(8'd7, 8'd14, 8'd3, 8'd19, 8'd1, 8'd38, 8'd20);
      queue_fields(8'd0, 8'd0, 8'd0, 8'd29, 8'd2, 8'd24, 8'd20);
      queue_fields(8'd59, 8'd59, 8'd23, 8'd31, 8'd13, 8'd99, 8'd19);
      queue_fields(8'd0, 8'd0, 8'd0, 8'd1, 8'd14, 8'd0, 8'd21);
      queue_fields(8'd0, 8'd0, 8'd0, 8'd1, 8'd15, 8'd0, 8'd21);
      queue_fields(8'd0, 8'd0, 8'd0, 8'd1, 8'd26, 8'd0, 8'd21);
      queue_fields(8'd59, 8'd59, 8'd23, 8'd31, 8'd12, 8'd69, 8'd19);
      wait_for_drain();

      for (int phase = 0; phase < 4; phase++) begin
         write_binary_mode(phase[0]);
         for (int n = 0; n < 125; n++)
            queue_stamp(random_stamp(binary_model));
         wait_for_drain();
      end

      repeat (12) @(negedge clock);
      $display("checked %0d conversions over %0d binary mode writes, bcd and binary bytes",
               checked_count, csr_writes);
      $display("directed edges: epoch, pre-epoch, leap days, odd months, bad bcd nibbles");
      if (mismatch_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
